// ===== sv/ioubf_pkg.sv =====
package ioubf_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    localparam int ACTION_W    = 2;
    localparam int FIELD_W     = 12;
    localparam int THR_W       = 8;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_INDEX_W = 1;

    // action + four coordinates, padded to whole bytes
    localparam int S_TDATA_W = 56;
    // accepted + stored_count + table_full, padded to whole bytes
    localparam int M_TDATA_W = 16;

    localparam logic [THR_W-1:0] THR_NUM_RESET = 8'd9;
    localparam logic [THR_W-1:0] THR_DEN_RESET = 8'd10;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_STORE = 2'd1,
        ACT_TEST  = 2'd2
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THR_NUM = 1'b0,
        REG_THR_DEN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic accepted;
        logic table_full;
    } flags_t;

endpackage

// ===== sv/ioubf_mul.sv =====
module ioubf_mul #(
    parameter int A_W = 25,
    parameter int B_W = 12
) (
    input  logic               aclk,
    input  logic [A_W-1:0]     op_a,
    input  logic [B_W-1:0]     op_b,
    output logic [A_W+B_W-1:0] prod
);

    logic [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== sv/ioubf_box_mem.sv =====
module ioubf_box_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 48
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] box_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            box_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= box_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ioubf_ctrl.sv =====
module ioubf_ctrl #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12,
    localparam int CNT_W     = $clog2(MAX_BOXES + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  ioubf_pkg::action_t                action,
    input  logic [ioubf_pkg::FIELD_W-1:0]     cand_x,
    input  logic [ioubf_pkg::FIELD_W-1:0]     cand_y,
    input  logic [ioubf_pkg::FIELD_W-1:0]     cand_w,
    input  logic [ioubf_pkg::FIELD_W-1:0]     cand_h,
    input  logic [ioubf_pkg::THR_W-1:0]       thr_num,
    input  logic [ioubf_pkg::THR_W-1:0]       thr_den,
    input  logic                              out_ready,
    output logic                              idle,
    output logic                              done,
    output ioubf_pkg::flags_t                 flags,
    output logic [CNT_W-1:0]                  count
);

    import ioubf_pkg::*;

    localparam int CW     = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int AW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int BOX_W  = 4 * CW;
    localparam int AREA_W = 2 * CW;
    localparam int UNI_W  = 2 * CW + 1;
    localparam int MA_W   = UNI_W;
    localparam int MB_W   = (CW > THR_W) ? CW : THR_W;
    localparam int P_W    = MA_W + MB_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CAREA = 9'b000000010,
        S_EDGE  = 9'b000000100,
        S_INTER = 9'b000001000,
        S_UNION = 9'b000010000,
        S_LHS   = 9'b000100000,
        S_RHS   = 9'b001000000,
        S_CMP   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_inc;
    logic [BOX_W-1:0]   cand_reg;
    logic [BOX_W-1:0]   cand_in;
    logic [BOX_W-1:0]   rd_box;
    logic [AREA_W-1:0]  area_a_reg, area_b_reg, inter_reg;
    logic [UNI_W-1:0]   uni_reg;
    logic [P_W-1:0]     lhs_reg;
    logic [CW-1:0]      iw_reg, ih_reg;
    flags_t             flags_reg;

    logic [CW-1:0]      ax, ay, aw, ah, bx, by, bw, bh;
    logic [CW-1:0]      lx, ly;
    logic [CW:0]        a_rx, a_ry, b_rx, b_ry, rx, ry, iw_full, ih_full;
    logic [MA_W-1:0]    op_a;
    logic [MB_W-1:0]    op_b;
    logic [P_W-1:0]     mul_p;
    logic               mem_wr_en;
    logic [AW-1:0]      rd_addr;
    logic               reject;

    // coordinates masked to the configured width, packed {h, w, y, x}
    assign cand_in = {cand_h[CW-1:0], cand_w[CW-1:0], cand_y[CW-1:0], cand_x[CW-1:0]};

    assign {ah, aw, ay, ax} = cand_reg;
    assign {bh, bw, by, bx} = rd_box;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign mem_wr_en = start && (state_reg == S_IDLE) && (action == ACT_STORE)
                       && (cnt_reg < CNT_MAX);
    // next entry is fetched during the compare so it is ready at the edge step
    assign rd_addr   = (state_reg == S_CMP) ? idx_inc[AW-1:0] : idx_reg[AW-1:0];

    ioubf_box_mem #(
        .DEPTH  (MAX_BOXES),
        .ADDR_W (AW),
        .DATA_W (BOX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (cand_in),
        .rd_addr (rd_addr),
        .rd_data (rd_box)
    );

    ioubf_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (mul_p)
    );

    // intersection edges
    assign lx      = (ax > bx) ? ax : bx;
    assign ly      = (ay > by) ? ay : by;
    assign a_rx    = {1'b0, ax} + {1'b0, aw};
    assign a_ry    = {1'b0, ay} + {1'b0, ah};
    assign b_rx    = {1'b0, bx} + {1'b0, bw};
    assign b_ry    = {1'b0, by} + {1'b0, bh};
    assign rx      = (a_rx < b_rx) ? a_rx : b_rx;
    assign ry      = (a_ry < b_ry) ? a_ry : b_ry;
    assign iw_full = (rx > {1'b0, lx}) ? rx - {1'b0, lx} : '0;
    assign ih_full = (ry > {1'b0, ly}) ? ry - {1'b0, ly} : '0;

    // in the compare step the multiplier output holds num * union
    assign reject = (inter_reg != '0) && (lhs_reg > mul_p);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_CAREA: begin
                op_a = MA_W'(aw);
                op_b = MB_W'(ah);
            end
            S_EDGE: begin
                op_a = MA_W'(bw);
                op_b = MB_W'(bh);
            end
            S_INTER: begin
                op_a = MA_W'(iw_reg);
                op_b = MB_W'(ih_reg);
            end
            S_LHS: begin
                op_a = MA_W'(inter_reg);
                op_b = MB_W'(thr_den);
            end
            S_RHS: begin
                op_a = uni_reg;
                op_b = MB_W'(thr_num);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_DONE;
                    unique case (action)
                        ACT_CLEAR: cnt_next = '0;
                        ACT_STORE: begin
                            if (cnt_reg < CNT_MAX) begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        ACT_TEST: begin
                            if (cnt_reg != '0) begin
                                state_next = S_CAREA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CAREA: state_next = S_EDGE;
            S_EDGE:  state_next = S_INTER;
            S_INTER: state_next = S_UNION;
            S_UNION: state_next = S_LHS;
            S_LHS:   state_next = S_RHS;
            S_RHS:   state_next = S_CMP;
            S_CMP: begin
                if (reject || (idx_inc == cnt_reg)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_EDGE;
                end
            end
            S_DONE: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cand_reg             <= cand_in;
                    idx_reg              <= '0;
                    flags_reg.accepted   <= (action == ACT_TEST);
                    flags_reg.table_full <= (action == ACT_STORE) && (cnt_reg == CNT_MAX);
                end
            end
            S_EDGE: begin
                iw_reg <= iw_full[CW-1:0];
                ih_reg <= ih_full[CW-1:0];
                // candidate area comes out of the multiplier only before the first box
                if (idx_reg == '0) begin
                    area_a_reg <= mul_p[AREA_W-1:0];
                end
            end
            S_INTER: area_b_reg <= mul_p[AREA_W-1:0];
            S_UNION: begin
                inter_reg <= mul_p[AREA_W-1:0];
                uni_reg   <= UNI_W'(area_a_reg) + UNI_W'(area_b_reg)
                             - UNI_W'(mul_p[AREA_W-1:0]);
            end
            S_RHS: lhs_reg <= mul_p;
            S_CMP: begin
                if (reject) begin
                    flags_reg.accepted <= 1'b0;
                end
                idx_reg <= idx_inc;
            end
            default: begin
            end
        endcase
    end

    assign idle  = (state_reg == S_IDLE);
    assign done  = (state_reg == S_DONE);
    assign flags = flags_reg;
    assign count = cnt_reg;

endmodule

// ===== sv/iou_duplicate_box_filter.sv =====
// iou duplicate box filter
// input stream (s_*) carries one action per transaction: clear the box table,
// store a box, or test a candidate box against every stored box. a candidate
// is rejected when inter * threshold_den > threshold_num * union for any
// stored box. the output stream (m_*) returns one result per input
// transaction: accepted flag, stored box count and table-full flag.
// clear, store and unused actions, and a test on an empty table, go from idle
// straight to the done step and hand their result to the output register.
// a test on a non-empty table first reckons the candidate area, then scans the
// stored boxes in order and stops at the first rejection (all of them are
// scanned when accepted): the single shared multiplier is used four times per
// stored box, and each box costs six steps of the sequencer.
// s_tready is high only while the sequencer is idle and out of reset; one item
// is in work at a time. a finished result waits in the output register while
// m_tready is low, and the next item can be taken meanwhile; its result is
// held in the sequencer until the register frees up.
// reset empties the table and loads thresholds 9 / 10. configuration writes
// (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and belong in idle
// time.
module iou_duplicate_box_filter #(
    parameter int MAX_BOXES  = ioubf_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = ioubf_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[1:0], box_x[13:2], box_y[25:14], box_w[37:26], box_h[49:38]
    input  logic [ioubf_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accepted[0], stored_count[7:1], table_full[8]
    output logic [ioubf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ioubf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ioubf_pkg::THR_W-1:0]         cfg_wdata
);

    import ioubf_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [THR_W-1:0]             thr_num_reg, thr_den_reg;
    logic                         m_tvalid_reg;
    logic                         m_accepted_reg, m_full_reg;
    logic [COUNT_OUT_W-1:0]       m_count_reg;

    logic                         s_accept;
    action_t                      s_action;
    logic                         ctrl_idle, ctrl_done;
    flags_t                       ctrl_flags;
    logic [CNT_W-1:0]             ctrl_count;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
    logic                         out_free;

    assign s_action = action_t'(s_tdata[ACTION_W-1:0]);
    assign s_tready = ctrl_idle && aresetn;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    ioubf_ctrl #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept),
        .action    (s_action),
        .cand_x    (s_tdata[ACTION_W +: FIELD_W]),
        .cand_y    (s_tdata[ACTION_W + FIELD_W +: FIELD_W]),
        .cand_w    (s_tdata[ACTION_W + 2*FIELD_W +: FIELD_W]),
        .cand_h    (s_tdata[ACTION_W + 3*FIELD_W +: FIELD_W]),
        .thr_num   (thr_num_reg),
        .thr_den   (thr_den_reg),
        .out_ready (out_free),
        .idle      (ctrl_idle),
        .done      (ctrl_done),
        .flags     (ctrl_flags),
        .count     (ctrl_count)
    );

    // count reported modulo the 7-bit field
    assign count_ext = {{COUNT_OUT_W{1'b0}}, ctrl_count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_num_reg <= THR_NUM_RESET;
            thr_den_reg <= THR_DEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THR_NUM: thr_num_reg <= cfg_wdata;
                REG_THR_DEN: thr_den_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= ctrl_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && ctrl_done) begin
            m_accepted_reg <= ctrl_flags.accepted;
            m_full_reg     <= ctrl_flags.table_full;
            m_count_reg    <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_OUT_W - 2){1'b0}},
                       m_full_reg, m_count_reg, m_accepted_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_count <= CNT_W'(MAX_BOXES))
        else $error("box count beyond table depth");

    a_full_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_done && ctrl_flags.table_full |-> ctrl_count == CNT_W'(MAX_BOXES))
        else $error("table full reported with free entries");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_done |-> !(ctrl_flags.accepted && ctrl_flags.table_full))
        else $error("accepted and table full in one result");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_action == ACT_CLEAR) |=> ctrl_count == '0)
        else $error("clear did not empty the table");
`endif

endmodule
